>>> hw/rtl/nld_pkg.sv
// Shared constants and types for the newline line deframer.
package nld_pkg;

  localparam int FRAME_MAX = 64;
  localparam int LINE_CAP = FRAME_MAX - 1;
  localparam int FILL_W = $clog2(FRAME_MAX);
  localparam int BANK_DEPTH = 2 ** FILL_W;
  localparam int STORE_DEPTH = 2 * BANK_DEPTH;
  localparam int ADDR_W = FILL_W + 1;
  localparam int BYTE_W = 8;
  localparam int LEN_OUT_W = 6;
  localparam int DROP_W = 16;
  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

  localparam logic [BYTE_W-1:0] CH_NL = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR = 8'd13;

  typedef struct packed {
    logic              bank;
    logic [FILL_W-1:0] len;
    logic [DROP_W-1:0] drop;
  } line_cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    data;
    logic                 last;
    logic [LEN_OUT_W-1:0] len;
    logic [DROP_W-1:0]    drop;
  } out_word_t;

endpackage

>>> hw/rtl/nld_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/nld_front.sv
// Front end: takes received bytes, fills the line store and classifies line ends.
module nld_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [nld_pkg::BYTE_W-1:0]    rx_byte,
  input  logic                          push,
  output logic                          full,
  input  logic                          cmd_ready,
  output logic                          cmd_push,
  output nld_pkg::line_cmd_t            cmd,
  output logic                          ram_we,
  output logic [nld_pkg::ADDR_W-1:0]    ram_waddr,
  output logic [nld_pkg::BYTE_W-1:0]    ram_wdata
);

  localparam logic [nld_pkg::FILL_W-1:0] CAP = nld_pkg::FILL_W'(nld_pkg::LINE_CAP);
  localparam logic [nld_pkg::DROP_W-1:0] DROP_MAX = '1;

  logic                        bank;
  logic [nld_pkg::FILL_W-1:0]  fill;
  logic                        overflowed;
  logic                        last_cr;
  logic [nld_pkg::DROP_W-1:0]  drop_tally;

  logic                        accept;
  logic                        is_nl;
  logic [nld_pkg::FILL_W-1:0]  line_len;

  always_comb begin
    full = !cmd_ready;
    accept = push && cmd_ready;
    is_nl = (rx_byte == nld_pkg::CH_NL);
    line_len = (last_cr && (fill != '0)) ? fill - 1'b1 : fill;
    ram_we = accept && !is_nl && !overflowed && (fill != CAP);
    ram_waddr = {bank, fill};
    ram_wdata = rx_byte;
    cmd_push = accept && is_nl && !overflowed && (line_len != '0);
    cmd.bank = bank;
    cmd.len = line_len;
    cmd.drop = drop_tally;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
      fill <= '0;
      overflowed <= 1'b0;
      last_cr <= 1'b0;
      drop_tally <= '0;
    end else if (accept) begin
      if (is_nl) begin
        if (overflowed) begin
          overflowed <= 1'b0;
          if (drop_tally != DROP_MAX) begin
            drop_tally <= drop_tally + 1'b1;
          end
        end else if (cmd_push) begin
          bank <= !bank;
        end
        fill <= '0;
      end else if (!overflowed) begin
        if (fill == CAP) begin
          overflowed <= 1'b1;
        end else begin
          fill <= fill + 1'b1;
          last_cr <= (rx_byte == nld_pkg::CH_CR);
        end
      end
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= CAP) else $error("fill count beyond line capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> fill == CAP) else $error("overflow set with room in store");

endmodule

>>> hw/rtl/nld_cmdq.sv
// Two-entry queue of finished line commands between front and back end.
module nld_cmdq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  nld_pkg::line_cmd_t wr_cmd,
  output logic               ready,
  output logic               valid,
  output nld_pkg::line_cmd_t rd_cmd,
  input  logic               pop
);

  nld_pkg::line_cmd_t entries [nld_pkg::CMDQ_DEPTH];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  always_comb begin
    ready = (count != 2'd2);
    valid = (count != 2'd0);
    rd_cmd = entries[rp];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= wr_cmd;
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> ready) else $error("command pushed into full queue");

endmodule

>>> hw/rtl/nld_back.sv
// Back end: reads stored lines out byte by byte into the result queue.
module nld_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  nld_pkg::line_cmd_t             cmd,
  output logic                           cmd_pop,
  output logic [nld_pkg::ADDR_W-1:0]     ram_raddr,
  input  logic [nld_pkg::BYTE_W-1:0]     ram_rdata,
  output logic [nld_pkg::BYTE_W-1:0]     line_byte,
  output logic                           line_last,
  output logic [nld_pkg::LEN_OUT_W-1:0]  line_length,
  output logic [nld_pkg::DROP_W-1:0]     dropped_lines,
  output logic                           empty,
  input  logic                           pop
);

  localparam int CNT_W = nld_pkg::OUTQ_PTR_W + 1;

  logic [nld_pkg::FILL_W-1:0]     idx;
  logic                           rd_valid;
  logic                           rd_last;
  logic [nld_pkg::LEN_OUT_W-1:0]  rd_len;
  logic [nld_pkg::DROP_W-1:0]     rd_drop;

  nld_pkg::out_word_t             outq [nld_pkg::OUTQ_DEPTH];
  logic [nld_pkg::OUTQ_PTR_W-1:0] owp;
  logic [nld_pkg::OUTQ_PTR_W-1:0] orp;
  logic [CNT_W-1:0]               ocnt;

  logic                           issue;
  logic                           is_last;
  logic                           pop_acc;
  logic [CNT_W:0]                 in_use;
  nld_pkg::out_word_t             head;
  nld_pkg::out_word_t             new_word;

  always_comb begin
    in_use = {1'b0, ocnt} + (CNT_W + 1)'(rd_valid);
    issue = cmd_valid && (in_use < (CNT_W + 1)'(nld_pkg::OUTQ_DEPTH));
    is_last = (idx + 1'b1 == cmd.len);
    cmd_pop = issue && is_last;
    ram_raddr = {cmd.bank, idx};
    empty = (ocnt == '0);
    pop_acc = pop && !empty;
    head = outq[orp];
    line_byte = head.data;
    line_last = head.last;
    line_length = head.len;
    dropped_lines = head.drop;
    new_word.data = ram_rdata;
    new_word.last = rd_last;
    new_word.len = rd_len;
    new_word.drop = rd_drop;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_last <= is_last;
      rd_len <= nld_pkg::LEN_OUT_W'(cmd.len);
      rd_drop <= cmd.drop;
    end
    if (rd_valid) begin
      outq[owp] <= new_word;
    end
    if (rst) begin
      idx <= '0;
      rd_valid <= 1'b0;
      owp <= '0;
      orp <= '0;
      ocnt <= '0;
    end else begin
      rd_valid <= issue;
      if (issue) begin
        idx <= is_last ? '0 : idx + 1'b1;
      end
      if (rd_valid) begin
        owp <= owp + 1'b1;
      end
      if (pop_acc) begin
        orp <= orp + 1'b1;
      end
      ocnt <= ocnt + CNT_W'(rd_valid) - CNT_W'(pop_acc);
    end
  end

  a_credit: assert property (@(posedge clk) disable iff (rst)
    in_use <= (CNT_W + 1)'(nld_pkg::OUTQ_DEPTH)) else $error("result queue overcommitted");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> idx < cmd.len) else $error("read index beyond line length");

endmodule

>>> hw/rtl/newline_line_deframer.sv
// Top level of the newline line deframer.
// Bytes are taken one per cycle while full is low; a line of up to 63 bytes is
// collected in one of two banks of the line store, and at its newline a single
// trailing carriage return is removed and the line is handed to the read-out
// side. A line of n bytes leaves as n words, one per cycle while pop is held;
// its first word passes the command queue, the line store read port and the
// result queue. Full rises only while two finished lines wait for read-out,
// so while pop is held the front end stalls for at most one line's read-out
// time; while pop stays low it stalls for as long as pop does. Empty and
// oversize lines produce no words; oversize lines are counted in dropped_lines.
module newline_line_deframer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [nld_pkg::BYTE_W-1:0]    rx_byte,
  input  logic                          push,
  output logic                          full,
  output logic [nld_pkg::BYTE_W-1:0]    line_byte,
  output logic                          line_last,
  output logic [nld_pkg::LEN_OUT_W-1:0] line_length,
  output logic [nld_pkg::DROP_W-1:0]    dropped_lines,
  output logic                          empty,
  input  logic                          pop
);

  logic                       q_ready;
  logic                       q_push;
  logic                       q_valid;
  logic                       q_pop;
  nld_pkg::line_cmd_t         q_wr_cmd;
  nld_pkg::line_cmd_t         q_rd_cmd;
  logic                       ram_we;
  logic [nld_pkg::ADDR_W-1:0] ram_waddr;
  logic [nld_pkg::BYTE_W-1:0] ram_wdata;
  logic [nld_pkg::ADDR_W-1:0] ram_raddr;
  logic [nld_pkg::BYTE_W-1:0] ram_rdata;

  nld_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx_byte),
    .push      (push),
    .full      (full),
    .cmd_ready (q_ready),
    .cmd_push  (q_push),
    .cmd       (q_wr_cmd),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  nld_ram #(
    .WIDTH (nld_pkg::BYTE_W),
    .DEPTH (nld_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nld_cmdq u_cmdq (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_cmd (q_wr_cmd),
    .ready  (q_ready),
    .valid  (q_valid),
    .rd_cmd (q_rd_cmd),
    .pop    (q_pop)
  );

  nld_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (q_valid),
    .cmd           (q_rd_cmd),
    .cmd_pop       (q_pop),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .line_byte     (line_byte),
    .line_last     (line_last),
    .line_length   (line_length),
    .dropped_lines (dropped_lines),
    .empty         (empty),
    .pop           (pop)
  );

endmodule
